// File: rtl/cbd_pkg.sv
// cbd_pkg: shared types, widths, register codes and color widening tables
// for the color blob detector. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cbd_pkg;

  // Raster limits; coordinates saturate at the last column and row.
  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;

  localparam int CoordW   = 10;
  localparam int CountW   = 21;
  localparam int SumW     = 31;
  localparam int StepW    = 8;
  localparam int FracBits = 16;
  localparam int FracW    = FracBits + 1;
  localparam int Prod1W   = CountW + StepW;
  localparam int Prod2W   = Prod1W + StepW;
  localparam int DivW     = Prod2W + FracBits;
  localparam int DivCntW  = $clog2(DivW);
  localparam int CfgDataW = 24;
  localparam int CfgIdxW  = 3;

  localparam logic [CoordW-1:0] ColLast  = CoordW'(MaxWidth - 1);
  localparam logic [CoordW-1:0] RowLast  = CoordW'(MaxHeight - 1);
  localparam logic [CountW-1:0] HitMax   = {CountW{1'b1}};
  localparam logic [FracW-1:0]  FracOne  = FracW'(1 << FracBits);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET    = 3'd0,
    CFG_TOLERANCE = 3'd1,
    CFG_STEP      = 3'd2,
    CFG_X_START   = 3'd3,
    CFG_Y_START   = 3'd4,
    CFG_X_END     = 3'd5,
    CFG_Y_END     = 3'd6,
    CFG_AREA      = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIV_COL,
    DIV_ROW,
    DIV_AREA
  } div_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_LDX,
    ST_DVX,
    ST_LDY,
    ST_DVY,
    ST_LDA,
    ST_DVA,
    ST_FRAC,
    ST_OUT
  } ctl_state_e;

  typedef struct packed {
    logic [15:0] pixel_word;
    logic        end_of_line;
    logic        end_of_frame;
  } pix_in_t;

  typedef struct packed {
    logic              found;
    logic [CoordW-1:0] centroid_x;
    logic [CoordW-1:0] centroid_y;
    logic [CoordW-1:0] box_left;
    logic [CoordW-1:0] box_top;
    logic [CoordW-1:0] box_right;
    logic [CoordW-1:0] box_bottom;
    logic [CountW-1:0] match_count;
    logic [FracW-1:0]  area_fraction;
  } blob_out_t;

  // Controller -> datapath
  typedef struct packed {
    logic     pix_fire;
    logic     mul1;
    logic     mul2;
    logic     div_load;
    div_sel_e div_sel;
    logic     div_step;
    logic     store_col;
    logic     store_row;
    logic     store_area;
    logic     out_load;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic div_last;
  } dp_sts_t;

  // Rounded 5/6-bit to 8-bit widening, built at elaboration.
  typedef logic [7:0] wide5_tab_t [32];
  typedef logic [7:0] wide6_tab_t [64];

  function automatic wide5_tab_t build_wide5();
    wide5_tab_t t;
    for (int v = 0; v < 32; v++) begin
      t[v] = 8'((v * 255 + 15) / 31);
    end
    return t;
  endfunction

  function automatic wide6_tab_t build_wide6();
    wide6_tab_t t;
    for (int v = 0; v < 64; v++) begin
      t[v] = 8'((v * 255 + 31) / 63);
    end
    return t;
  endfunction

  localparam wide5_tab_t Wide5Tab = build_wide5();
  localparam wide6_tab_t Wide6Tab = build_wide6();

endpackage

`default_nettype wire

// File: rtl/rgb565_color_blob_detector_core.sv
// Throughput: one pixel word per cycle while no frame end is in progress;
//   in_ready_o is low from the end-of-frame word until the result is handed
//   to the output register, through the 53 one-bit steps of the shared
//   divider run three times (two centroids, area fraction), and longer
//   while an earlier result word still waits in the output register.
// Reset (rst_ni, async, active low): config to defaults, position and
//   accumulators cleared, min box corners to all ones, no result pending.
// rgb565_color_blob_detector_core: top level, joins controller and datapath.
// Depends on cbd_pkg, cbd_ctrl, cbd_datapath.
`timescale 1ns / 1ps
`default_nettype none

module rgb565_color_blob_detector_core (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // config write port, index is the register's place in the map
  input  wire                          cfg_we_i,
  input  wire [cbd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [cbd_pkg::CfgDataW-1:0]  cfg_data_i,
  // pixel word in
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  cbd_pkg::pix_in_t             in_word_i,
  // blob result word out
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output cbd_pkg::blob_out_t           out_word_o
);
  import cbd_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Controller: accepts pixels in idle, then sequences multiply, three
  // divisions and the handoff into the result register. The result register
  // is separate, so new pixels flow while an old result still waits.
  cbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_eof_i    (in_word_i.end_of_frame),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: per-pixel match and accumulate as each word is taken; frame-end math.
  cbd_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_word_o)
  );

endmodule

`default_nettype wire

// File: rtl/cbd_ctrl.sv
// cbd_ctrl: frame-end sequencer (multiply, three divisions, result handoff)
// and channel handshakes. Depends on cbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbd_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  input  wire              in_eof_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  input  cbd_pkg::dp_sts_t sts_i,
  output cbd_pkg::dp_cmd_t cmd_o
);
  import cbd_pkg::*;

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i && in_eof_i) state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_LDX;
      ST_LDX:  state_d = ST_DVX;
      ST_DVX:  if (sts_i.div_last) state_d = ST_LDY;
      ST_LDY:  state_d = ST_DVY;
      ST_DVY:  if (sts_i.div_last) state_d = ST_LDA;
      ST_LDA:  state_d = ST_DVA;
      ST_DVA:  if (sts_i.div_last) state_d = ST_FRAC;
      ST_FRAC: state_d = ST_OUT;
      ST_OUT:  if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.pix_fire = in_valid_i;
      end
      ST_MUL1: cmd_o.mul1 = 1'b1;
      ST_MUL2: cmd_o.mul2 = 1'b1;
      ST_LDX: begin
        cmd_o.div_load = 1'b1;
        cmd_o.div_sel  = DIV_COL;
      end
      ST_LDY: begin
        cmd_o.store_col = 1'b1;
        cmd_o.div_load  = 1'b1;
        cmd_o.div_sel   = DIV_ROW;
      end
      ST_LDA: begin
        cmd_o.store_row = 1'b1;
        cmd_o.div_load  = 1'b1;
        cmd_o.div_sel   = DIV_AREA;
      end
      ST_DVX, ST_DVY, ST_DVA: cmd_o.div_step = 1'b1;
      ST_FRAC: cmd_o.store_area = 1'b1;
      ST_OUT:  cmd_o.out_load = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/cbd_datapath.sv
// cbd_datapath: config registers, raster position, match test, accumulators,
// shared shift-subtract divider and result register. Depends on cbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbd_datapath (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [cbd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire [cbd_pkg::CfgDataW-1:0]    cfg_data_i,
  input  cbd_pkg::pix_in_t               in_word_i,
  input  cbd_pkg::dp_cmd_t               cmd_i,
  output cbd_pkg::dp_sts_t               sts_o,
  output cbd_pkg::blob_out_t             out_word_o
);
  import cbd_pkg::*;

  // Config
  logic [23:0]       target_q;
  logic [7:0]        tol_q;
  logic [StepW-1:0]  step_q;
  logic [CoordW-1:0] xs_q, ys_q, xe_q, ye_q;
  logic [CountW-1:0] area_cfg_q;

  // Raster position
  logic [CoordW-1:0] col_q, col_d, row_q, row_d;
  logic [StepW-1:0]  cph_q, cph_d, rph_q, rph_d;

  // Accumulators
  logic [CountW-1:0] hit_q, hit_d;
  logic [SumW-1:0]   sumc_q, sumc_d, sumr_q, sumr_d;
  logic [CoordW-1:0] minc_q, minc_d, maxc_q, maxc_d;
  logic [CoordW-1:0] minr_q, minr_d, maxr_q, maxr_d;

  // Frame-end arithmetic
  logic [Prod1W-1:0]  prod1_q;
  logic [Prod2W-1:0]  prod2_q;
  logic [DivW-1:0]    quo_q;
  logic [CountW-1:0]  rem_q;
  logic [CountW-1:0]  dvs_q;
  logic [DivCntW-1:0] cnt_q;
  logic [CoordW-1:0]  cenx_q, ceny_q;
  logic [FracW-1:0]   frac_q;
  blob_out_t          out_q;

  logic [StepW-1:0]  st_eff;
  logic [CountW-1:0] fa_eff;
  logic [7:0]        r8, g8, b8;
  logic              in_x, in_y, on_grid, color_ok, hit;
  logic [CountW:0]   rem_sh, rem_sub;
  logic              rem_ge;

  function automatic logic [7:0] absdiff(logic [7:0] a, logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [StepW-1:0] next_phase(logic [StepW-1:0] ph,
                                                  logic [StepW-1:0] st);
    logic [StepW:0] inc;
    inc = {1'b0, ph} + (StepW+1)'(1);
    return (inc >= {1'b0, st}) ? '0 : inc[StepW-1:0];
  endfunction

  assign st_eff = (step_q == '0) ? StepW'(1) : step_q;
  assign fa_eff = (area_cfg_q == '0) ? CountW'(1) : area_cfg_q;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= 24'hFF0000;
      tol_q      <= 8'd25;
      step_q     <= StepW'(1);
      xs_q       <= '0;
      ys_q       <= '0;
      xe_q       <= ColLast;
      ye_q       <= RowLast;
      area_cfg_q <= CountW'(1 << 20);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_TARGET:    target_q   <= cfg_data_i;
        CFG_TOLERANCE: tol_q      <= cfg_data_i[7:0];
        CFG_STEP:      step_q     <= cfg_data_i[StepW-1:0];
        CFG_X_START:   xs_q       <= cfg_data_i[CoordW-1:0];
        CFG_Y_START:   ys_q       <= cfg_data_i[CoordW-1:0];
        CFG_X_END:     xe_q       <= cfg_data_i[CoordW-1:0];
        CFG_Y_END:     ye_q       <= cfg_data_i[CoordW-1:0];
        CFG_AREA:      area_cfg_q <= cfg_data_i[CountW-1:0];
      endcase
    end
  end

  // Match test
  assign r8 = Wide5Tab[in_word_i.pixel_word[15:11]];
  assign g8 = Wide6Tab[in_word_i.pixel_word[10:5]];
  assign b8 = Wide5Tab[in_word_i.pixel_word[4:0]];

  assign in_x     = (col_q >= xs_q) && (col_q <= xe_q);
  assign in_y     = (row_q >= ys_q) && (row_q <= ye_q);
  assign on_grid  = (cph_q == '0) && (rph_q == '0);
  assign color_ok = (absdiff(r8, target_q[23:16]) <= tol_q) &&
                    (absdiff(g8, target_q[15:8]) <= tol_q) &&
                    (absdiff(b8, target_q[7:0]) <= tol_q);
  assign hit      = cmd_i.pix_fire && in_x && in_y && on_grid && color_ok;

  // Position update
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    cph_d = cph_q;
    rph_d = rph_q;
    if (cmd_i.pix_fire) begin
      if (in_word_i.end_of_frame) begin
        col_d = '0;
        row_d = '0;
        cph_d = '0;
        rph_d = '0;
      end else if (in_word_i.end_of_line) begin
        if (row_q >= ys_q) rph_d = next_phase(rph_q, st_eff);
        col_d = '0;
        cph_d = '0;
        if (row_q < RowLast) row_d = row_q + CoordW'(1);
      end else begin
        if (col_q >= xs_q) cph_d = next_phase(cph_q, st_eff);
        if (col_q < ColLast) col_d = col_q + CoordW'(1);
      end
    end
  end

  // Accumulator update; cleared once the result is taken into out_q
  always_comb begin
    hit_d  = hit_q;
    sumc_d = sumc_q;
    sumr_d = sumr_q;
    minc_d = minc_q;
    maxc_d = maxc_q;
    minr_d = minr_q;
    maxr_d = maxr_q;
    if (cmd_i.out_load) begin
      hit_d  = '0;
      sumc_d = '0;
      sumr_d = '0;
      minc_d = '1;
      maxc_d = '0;
      minr_d = '1;
      maxr_d = '0;
    end else if (hit) begin
      if (hit_q != HitMax) begin
        hit_d  = hit_q + CountW'(1);
        sumc_d = sumc_q + SumW'(col_q);
        sumr_d = sumr_q + SumW'(row_q);
      end
      if (col_q < minc_q) minc_d = col_q;
      if (col_q > maxc_q) maxc_d = col_q;
      if (row_q < minr_q) minr_d = row_q;
      if (row_q > maxr_q) maxr_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      cph_q  <= '0;
      rph_q  <= '0;
      hit_q  <= '0;
      sumc_q <= '0;
      sumr_q <= '0;
      minc_q <= '1;
      maxc_q <= '0;
      minr_q <= '1;
      maxr_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      cph_q  <= cph_d;
      rph_q  <= rph_d;
      hit_q  <= hit_d;
      sumc_q <= sumc_d;
      sumr_q <= sumr_d;
      minc_q <= minc_d;
      maxc_q <= maxc_d;
      minr_q <= minr_d;
      maxr_q <= maxr_d;
    end
  end

  // Restoring divider, one quotient bit per cycle; remainder stays below a nonzero divisor
  assign rem_sh  = {rem_q, quo_q[DivW-1]};
  assign rem_ge  = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign sts_o.div_last = (cnt_q == DivCntW'(DivW - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) prod1_q <= Prod1W'(hit_q) * Prod1W'(st_eff);
    if (cmd_i.mul2) prod2_q <= Prod2W'(prod1_q) * Prod2W'(st_eff);
    if (cmd_i.div_load) begin
      rem_q <= '0;
      cnt_q <= '0;
      case (cmd_i.div_sel)
        DIV_COL: begin
          quo_q <= DivW'(sumc_q);
          dvs_q <= hit_q;
        end
        DIV_ROW: begin
          quo_q <= DivW'(sumr_q);
          dvs_q <= hit_q;
        end
        default: begin
          quo_q <= {prod2_q, {FracBits{1'b0}}};
          dvs_q <= fa_eff;
        end
      endcase
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? rem_sub[CountW-1:0] : rem_sh[CountW-1:0];
      quo_q <= {quo_q[DivW-2:0], rem_ge};
      cnt_q <= cnt_q + DivCntW'(1);
    end
    if (cmd_i.store_col) cenx_q <= quo_q[CoordW-1:0];
    if (cmd_i.store_row) ceny_q <= quo_q[CoordW-1:0];
    if (cmd_i.store_area) begin
      frac_q <= (quo_q > DivW'(FracOne)) ? FracOne : quo_q[FracW-1:0];
    end
    if (cmd_i.out_load) begin
      out_q <= '0;
      if (hit_q != '0) begin
        out_q.found         <= 1'b1;
        out_q.centroid_x    <= cenx_q;
        out_q.centroid_y    <= ceny_q;
        out_q.box_left      <= minc_q;
        out_q.box_top       <= minr_q;
        out_q.box_right     <= maxc_q;
        out_q.box_bottom    <= maxr_q;
        out_q.match_count   <= hit_q;
        out_q.area_fraction <= frac_q;
      end
    end
  end

  assign out_word_o = out_q;

endmodule

`default_nettype wire

// File: rtl/cbd_checker.sv
// cbd_checker: port-level assertions on the blob detector result channel,
// bound to the top level. Depends on cbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbd_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                out_valid_o,
  input wire                out_ready_i,
  input cbd_pkg::blob_out_t out_word_o
);
  import cbd_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // no match means an all-zero word
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.found |-> out_word_o == '0)
    else $error("empty frame result not zero");

  // a found blob has a proper box with the centroid inside
  a_box_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.found |->
      out_word_o.match_count != '0 &&
      out_word_o.box_left <= out_word_o.centroid_x &&
      out_word_o.centroid_x <= out_word_o.box_right &&
      out_word_o.box_top <= out_word_o.centroid_y &&
      out_word_o.centroid_y <= out_word_o.box_bottom)
    else $error("box or centroid inconsistent");

  // area fraction saturates at one
  a_frac_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.area_fraction <= FracOne)
    else $error("area fraction above one");

endmodule

bind rgb565_color_blob_detector_core cbd_checker u_cbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire

// File: tb/sv/rgb565_color_blob_detector_core_tb.sv
// Testbench for rgb565_color_blob_detector_core: drives raster frames of RGB565
// words, predicts each frame's blob word in step with accepted input, checks
// results. Depends on cbd_pkg and the core RTL.
`timescale 1ns / 1ps

module rgb565_color_blob_detector_core_tb;
  import cbd_pkg::*;

  localparam int DrainCycles   = 200;   // outlasts the end-of-frame latency
  localparam int WatchdogLimit = 4000;  // quiet cycles before giving up
  localparam int LongHold      = 600;   // receiver hold-off for backpressure

  // DUT ports
  logic       clk;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  cfg_reg_e   cfg_idx   = CFG_TARGET;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  pix_in_t    in_word   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  blob_out_t  out_word;

  // Register shadow, reset values of the block
  logic [23:0] tgt_color = 24'hFF0000;
  logic [7:0]  tol       = 8'd25;
  logic [7:0]  step      = 8'd1;
  logic [9:0]  roi_x0    = 10'd0;
  logic [9:0]  roi_y0    = 10'd0;
  logic [9:0]  roi_x1    = 10'd1023;
  logic [9:0]  roi_y1    = 10'd1023;
  logic [20:0] area_div  = 21'd1048576;

  // Frame accumulators of the blob predictor
  logic [9:0]  cur_col, cur_row, left_edge, right_edge, top_edge, bottom_edge;
  logic [7:0]  col_tick, row_tick;
  logic [CountW-1:0] hits;
  longint unsigned   col_sum, row_sum;

  blob_out_t pending_blobs[$];   // blob words owed by the block, oldest first
  int  blobs_seen    = 0;
  int  mismatches    = 0;
  int  words_sent    = 0;
  int  quiet_cycles  = 0;
  int  hold_cycles   = 0;        // long hold-off request for the receiver
  int  sink_stall    = 0;
  bit  src_gaps      = 1'b1;
  bit  sink_gaps     = 1'b1;

  rgb565_color_blob_detector_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Blob predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_blob_state();
    cur_col = '0;  cur_row = '0;  col_tick = '0;  row_tick = '0;
    hits = '0;  col_sum = 0;  row_sum = 0;
    left_edge = '1;  right_edge = '0;  top_edge = '1;  bottom_edge = '0;
  endfunction

  // Rounded widening of a 5- or 6-bit code to 8 bits
  function automatic int expand_channel(int code, int top);
    return (code * 255 + top / 2) / top;
  endfunction

  function automatic bit chan_close(int a, int b);
    return ((a > b) ? a - b : b - a) <= int'(tol);
  endfunction

  function automatic logic [7:0] next_tick(logic [7:0] tick);
    int stride;
    stride = (step == 0) ? 1 : int'(step);
    return (int'(tick) + 1 >= stride) ? 8'd0 : tick + 8'd1;
  endfunction

  // Fold one accepted pixel word into the frame; on frame end queue the blob word
  function automatic void track_blob_pixel(pix_in_t w);
    blob_out_t       blob;
    longint unsigned stride, div, frac;
    bit              in_roi;
    in_roi = cur_col >= roi_x0 && cur_col <= roi_x1 &&
             cur_row >= roi_y0 && cur_row <= roi_y1 &&
             col_tick == 0 && row_tick == 0;
    if (in_roi &&
        chan_close(expand_channel(w.pixel_word[15:11], 31), tgt_color[23:16]) &&
        chan_close(expand_channel(w.pixel_word[10:5], 63), tgt_color[15:8]) &&
        chan_close(expand_channel(w.pixel_word[4:0], 31), tgt_color[7:0])) begin
      // count and sums freeze once the counter is full; the box keeps moving
      if (hits < HitMax) begin
        hits++;
        col_sum += cur_col;
        row_sum += cur_row;
      end
      if (cur_col < left_edge)   left_edge   = cur_col;
      if (cur_col > right_edge)  right_edge  = cur_col;
      if (cur_row < top_edge)    top_edge    = cur_row;
      if (cur_row > bottom_edge) bottom_edge = cur_row;
    end

    if (w.end_of_frame) begin
      // end of frame also closes the line; eol alongside it changes nothing
      blob = '0;
      if (hits != 0) begin
        stride = (step == 0) ? 1 : step;
        div    = (area_div == 0) ? 1 : area_div;
        frac   = longint'(hits) * stride * stride * 65536 / div;
        if (frac > 65536) frac = 65536;
        blob.found         = 1'b1;
        blob.centroid_x    = 10'(col_sum / longint'(hits));
        blob.centroid_y    = 10'(row_sum / longint'(hits));
        blob.box_left      = left_edge;
        blob.box_top       = top_edge;
        blob.box_right     = right_edge;
        blob.box_bottom    = bottom_edge;
        blob.match_count   = hits;
        blob.area_fraction = 17'(frac);
      end
      pending_blobs.push_back(blob);
      clear_blob_state();
    end else if (w.end_of_line) begin
      if (cur_row >= roi_y0) row_tick = next_tick(row_tick);
      cur_col  = '0;
      col_tick = '0;
      if (cur_row != RowLast) cur_row++;
    end else begin
      if (cur_col >= roi_x0) col_tick = next_tick(col_tick);
      if (cur_col != ColLast) cur_col++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: receiver stalls and blob word check
  // ---------------------------------------------------------------------------

  task automatic compare_blob(blob_out_t got);
    blob_out_t want;
    string     bad;
    blobs_seen++;
    if (pending_blobs.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: blob word %0d with none expected: %p",
                                     blobs_seen, got);
      return;
    end
    want = pending_blobs.pop_front();
    bad  = "";
    if (got.found !== want.found)                 bad = {bad, " found"};
    if (got.centroid_x !== want.centroid_x)       bad = {bad, " centroid_x"};
    if (got.centroid_y !== want.centroid_y)       bad = {bad, " centroid_y"};
    if (got.box_left !== want.box_left)           bad = {bad, " box_left"};
    if (got.box_top !== want.box_top)             bad = {bad, " box_top"};
    if (got.box_right !== want.box_right)         bad = {bad, " box_right"};
    if (got.box_bottom !== want.box_bottom)       bad = {bad, " box_bottom"};
    if (got.match_count !== want.match_count)     bad = {bad, " match_count"};
    if (got.area_fraction !== want.area_fraction) bad = {bad, " area_fraction"};
    if (bad != "") begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: blob word %0d differs in%s\n  expected %p\n  actual   %p",
                 blobs_seen, bad, want, got);
    end
  endtask

  // Receiver: short random stalls, or one long hold-off when a test asks
  always @(posedge clk) begin : result_sink
    if (out_valid && out_ready) compare_blob(out_word);
    if (sink_stall > 0) begin
      sink_stall--;
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      sink_stall  = hold_cycles - 1;
      hold_cycles = 0;
      out_ready <= 1'b0;
    end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
      sink_stall = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("TIMEOUT: no word moved for %0d cycles", quiet_cycles);
        $display("rgb565_color_blob_detector_core verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one pixel word and hold it until taken
  task automatic send_pix(logic [15:0] pix, bit eol, bit eof);
    pix_in_t w;
    w.pixel_word   = pix;
    w.end_of_line  = eol;
    w.end_of_frame = eof;
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    track_blob_pixel(w);
    words_sent++;
  endtask

  // Stop offering, let every owed blob word drain, then sit out the latency
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_blobs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_TARGET:    tgt_color = val[23:0];
      CFG_TOLERANCE: tol       = val[7:0];
      CFG_STEP:      step      = val[7:0];
      CFG_X_START:   roi_x0    = val[9:0];
      CFG_Y_START:   roi_y0    = val[9:0];
      CFG_X_END:     roi_x1    = val[9:0];
      CFG_Y_END:     roi_y1    = val[9:0];
      CFG_AREA:      area_div  = val[20:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Full register set, written only once the block has gone idle
  task automatic load_settings(logic [23:0] tgt, logic [7:0] tl, logic [7:0] st,
                               logic [9:0] x0, logic [9:0] y0,
                               logic [9:0] x1, logic [9:0] y1, logic [20:0] ar);
    quiesce();
    write_reg(CFG_TARGET, tgt);
    write_reg(CFG_TOLERANCE, tl);
    write_reg(CFG_STEP, st);
    write_reg(CFG_X_START, x0);
    write_reg(CFG_Y_START, y0);
    write_reg(CFG_X_END, x1);
    write_reg(CFG_Y_END, y1);
    write_reg(CFG_AREA, ar);
  endtask

  function automatic int clamp_code(int v, int top);
    return (v < 0) ? 0 : (v > top) ? top : v;
  endfunction

  // A pixel whose widened channels land close to the current target
  function automatic logic [15:0] pixel_near_target();
    int r, g, b;
    r = clamp_code((int'(tgt_color[23:16]) * 31 + 127) / 255 +
                   int'($urandom_range(0, 2)) - 1, 31);
    g = clamp_code((int'(tgt_color[15:8]) * 63 + 127) / 255 +
                   int'($urandom_range(0, 2)) - 1, 63);
    b = clamp_code((int'(tgt_color[7:0]) * 31 + 127) / 255 +
                   int'($urandom_range(0, 2)) - 1, 31);
    return {5'(r), 6'(g), 5'(b)};
  endfunction

  // One raster frame; a noisy frame has ragged rows and stray line marks
  task automatic send_frame(int rows, int max_cols, int near_pct, bit noisy);
    int cols;
    bit last, eol;
    logic [15:0] pix;
    cols = max_cols;
    for (int r = 0; r < rows; r++) begin
      if (noisy) cols = $urandom_range(1, max_cols);
      for (int c = 0; c < cols; c++) begin
        last = (r == rows - 1) && (c == cols - 1);
        eol  = (c == cols - 1);
        if (last) eol = $urandom_range(0, 1);
        else if (noisy && $urandom_range(0, 7) == 0) eol = !eol;
        pix = ($urandom_range(0, 99) < near_pct) ? pixel_near_target()
                                                  : 16'($urandom);
        send_pix(pix, eol, last);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes and the named corner cases, a handful of words each
  task automatic run_directed_cases();
    // reset settings: red target; white and black miss, pure red hits twice,
    // last word carries line and frame marks together
    send_pix(16'hFFFF, 1'b0, 1'b0);
    send_pix(16'h0000, 1'b0, 1'b0);
    send_pix(16'hF800, 1'b0, 1'b0);
    send_pix(16'hF800, 1'b1, 1'b1);
    // step and area zero taken as 1, fraction saturates, frame mark alone
    load_settings(24'hFFFFFF, 8'd0, 8'd0, 10'd0, 10'd0, 10'd1023, 10'd1023, 21'd0);
    send_pix(16'hFFFF, 1'b0, 1'b0);
    send_pix(16'hFFFF, 1'b1, 1'b0);
    send_pix(16'hFFFF, 1'b0, 1'b0);
    send_pix(16'hFFFF, 1'b0, 1'b1);
    // region start past its end: nothing can match
    load_settings(24'hFFFFFF, 8'd255, 8'd1, 10'd5, 10'd3, 10'd2, 10'd1, 21'd1);
    send_pix(16'hFFFF, 1'b0, 1'b0);
    send_pix(16'hFFFF, 1'b1, 1'b0);
    send_pix(16'hFFFF, 1'b0, 1'b1);
    // widest stride, full tolerance: only the region origin is sampled
    load_settings(24'h000000, 8'd255, 8'd255, 10'd0, 10'd0, 10'd1023, 10'd1023,
                  21'd1048576);
    for (int i = 0; i < 9; i++)
      send_pix((i % 2) ? 16'hFFFF : 16'h0000, (i % 3) == 2, i == 8);
    // one-word frame, zero tolerance against an odd target
    load_settings(24'h123456, 8'd0, 8'd1, 10'd0, 10'd0, 10'd1023, 10'd1023,
                  21'h1FFFFF);
    send_pix(16'h0000, 1'b0, 1'b1);
  endtask

  // Receiver holds off while frames keep coming, so the core backs up;
  // then the sender waits for every owed word
  task automatic run_backpressure();
    load_settings(24'h00FF00, 8'd30, 8'd1, 10'd0, 10'd0, 10'd1023, 10'd1023, 21'd24);
    hold_cycles = LongHold;
    repeat (3) send_frame(4, 6, 50, 1'b0);
    quiesce();
  endtask

  // Random settings per phase, several frames each; some phases without gaps
  task automatic run_random_frames(int n_words);
    int stop_at;
    logic [23:0] tgt;
    logic [7:0]  tl, st;
    logic [9:0]  x0, y0, x1, y1;
    logic [20:0] ar;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      tgt = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 24'hFFFFFF : 24'h0)
                                         : 24'($urandom);
      case ($urandom_range(0, 9))
        0:       tl = 8'd0;
        1:       tl = 8'd255;
        default: tl = $urandom_range(0, 40);
      endcase
      case ($urandom_range(0, 9))
        0:       st = 8'd0;
        1:       st = 8'd255;
        default: st = $urandom_range(1, 3);
      endcase
      x0 = $urandom_range(0, 4);
      y0 = $urandom_range(0, 4);
      x1 = ($urandom_range(0, 5) == 0) ? 10'd1023 : 10'($urandom_range(0, 10));
      y1 = ($urandom_range(0, 5) == 0) ? 10'd1023 : 10'($urandom_range(0, 10));
      case ($urandom_range(0, 9))
        0:       ar = 21'd0;
        1:       ar = 21'h1FFFFF;
        default: ar = $urandom_range(1, 120);
      endcase
      load_settings(tgt, tl, st, x0, y0, x1, y1, ar);
      src_gaps  = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 6))
        send_frame($urandom_range(1, 6), $urandom_range(1, 8),
                   $urandom_range(20, 80), $urandom_range(0, 7) == 0);
    end
  endtask

  // Closing stretch at full rate on both sides
  task automatic run_steady_stream(int n_words);
    int stop_at;
    stop_at   = words_sent + n_words;
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    while (words_sent < stop_at)
      send_frame($urandom_range(1, 6), $urandom_range(1, 8), 60, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_blob_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed_cases();
    run_backpressure();
    run_random_frames(820);
    run_steady_stream(150);

    quiesce();
    if (mismatches == 0) begin
      $display("rgb565_color_blob_detector_core verification clean");
    end else begin
      $display("rgb565_color_blob_detector_core verification failed");
    end
    $finish;
  end

endmodule
